// ----- rtl/date_add_days_core_assert.svh -----
// Assertion macros for the date adder core.
`ifndef DATE_ADD_DAYS_CORE_ASSERT_SVH
`define DATE_ADD_DAYS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define DADD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define DADD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define DADD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DADD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/dadd_pkg.sv -----
package dadd_pkg;

	localparam int YEAR_BITS   = 14;
	localparam int OFFSET_BITS = 16;

	// Running day count: start day plus offset.
	localparam int DAY_W = OFFSET_BITS + 1;

	// Year mod 400 by restoring reduction: subtract 400 << k, k from RED_TOP to 0.
	localparam int REM_W   = YEAR_BITS + 1;
	localparam int RED_TOP = YEAR_BITS - 8;
	localparam int RED_CW  = (RED_TOP < 1) ? 1 : $clog2(RED_TOP + 1);
	localparam int MOD_W   = 9;

	localparam logic [REM_W-1:0]  QUAD_CENT = REM_W'(400);
	localparam logic [MOD_W-1:0]  CENT_1    = MOD_W'(100);
	localparam logic [MOD_W-1:0]  CENT_2    = MOD_W'(200);
	localparam logic [MOD_W-1:0]  CENT_3    = MOD_W'(300);
	localparam logic [MOD_W-1:0]  MOD_LAST  = MOD_W'(399);

	localparam logic [3:0] MON_NONE = 4'd0;
	localparam logic [3:0] MON_JAN  = 4'd1;
	localparam logic [3:0] MON_FEB  = 4'd2;
	localparam logic [3:0] MON_APR  = 4'd4;
	localparam logic [3:0] MON_JUN  = 4'd6;
	localparam logic [3:0] MON_SEP  = 4'd9;
	localparam logic [3:0] MON_NOV  = 4'd11;
	localparam logic [3:0] MON_DEC  = 4'd12;

	localparam logic [4:0] FEB_COMMON = 5'd28;
	localparam logic [4:0] LEN_SHORT  = 5'd30;
	localparam logic [4:0] LEN_LONG   = 5'd31;

	typedef struct packed {
		logic load;
		logic red_step;
		logic walk_step;
		logic out_load;
	} dadd_cmd_t;

	typedef struct packed {
		logic red_last;
		logic walk_done;
	} dadd_sts_t;

	function automatic logic [4:0] days_in(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			MON_FEB:                            len = leap ? FEB_COMMON + 5'd1 : FEB_COMMON;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
			default:                            len = LEN_LONG;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/dadd_ctrl.sv -----
module dadd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  dadd_pkg::dadd_sts_t sts,
	output dadd_pkg::dadd_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RED  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_HOLD = 4'b1000
	} dadd_state_t;

	dadd_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RED;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (sts.red_last) state_d = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done) begin
					if (slot_free) begin
						cmd.out_load = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/dadd_dp.sv -----
module dadd_dp (
	input  logic                              clk,
	input  dadd_pkg::dadd_cmd_t               cmd,
	output dadd_pkg::dadd_sts_t               sts,
	input  logic [4:0]                        start_day,
	input  logic [3:0]                        start_month,
	input  logic [dadd_pkg::YEAR_BITS-1:0]    start_year,
	input  logic [dadd_pkg::OFFSET_BITS-1:0]  days_away,
	output logic [4:0]                        new_day,
	output logic [3:0]                        new_month,
	output logic [dadd_pkg::YEAR_BITS-1:0]    new_year,
	output logic                              year_overflow
);

	logic [dadd_pkg::DAY_W-1:0]     day_q;
	logic [3:0]                     mon_q;
	logic [dadd_pkg::YEAR_BITS-1:0] year_q;
	logic                           ovf_q;
	logic [dadd_pkg::REM_W-1:0]     rem_q;
	logic [dadd_pkg::RED_CW-1:0]    red_k_q;

	logic [4:0]                     out_day_q;
	logic [3:0]                     out_mon_q;
	logic [dadd_pkg::YEAR_BITS-1:0] out_year_q;
	logic                           out_ovf_q;

	logic [dadd_pkg::REM_W-1:0]     red_sub;
	logic [dadd_pkg::MOD_W-1:0]     mod400;
	logic                           leap;
	logic [4:0]                     len;
	logic [3:0]                     mon_clamp;

	assign red_sub = dadd_pkg::QUAD_CENT << red_k_q;
	assign mod400  = rem_q[dadd_pkg::MOD_W-1:0];
	assign leap    = (year_q[1:0] == 2'b00) &&
	                 ((mod400 == '0) || !((mod400 == dadd_pkg::CENT_1) ||
	                                      (mod400 == dadd_pkg::CENT_2) ||
	                                      (mod400 == dadd_pkg::CENT_3)));
	assign len     = dadd_pkg::days_in(mon_q, leap);

	assign sts.red_last  = (red_k_q == '0);
	assign sts.walk_done = !(day_q > dadd_pkg::DAY_W'(len));

	always_comb begin
		if (start_month == dadd_pkg::MON_NONE)     mon_clamp = dadd_pkg::MON_JAN;
		else if (start_month > dadd_pkg::MON_DEC)  mon_clamp = dadd_pkg::MON_DEC;
		else                                       mon_clamp = start_month;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= dadd_pkg::DAY_W'(start_day) + dadd_pkg::DAY_W'(days_away);
			mon_q   <= mon_clamp;
			year_q  <= start_year;
			ovf_q   <= 1'b0;
			rem_q   <= dadd_pkg::REM_W'(start_year);
			red_k_q <= dadd_pkg::RED_CW'(dadd_pkg::RED_TOP);
		end else if (cmd.red_step) begin
			if (rem_q >= red_sub) rem_q <= rem_q - red_sub;
			if (red_k_q != '0) red_k_q <= red_k_q - 1'b1;
		end else if (cmd.walk_step && !sts.walk_done) begin
			day_q <= day_q - dadd_pkg::DAY_W'(len);
			if (mon_q == dadd_pkg::MON_DEC) begin
				mon_q <= dadd_pkg::MON_JAN;
				if (year_q == '1) begin
					year_q <= '0;
					ovf_q  <= 1'b1;
					rem_q  <= '0;
				end else begin
					year_q <= year_q + 1'b1;
					if (mod400 == dadd_pkg::MOD_LAST) rem_q <= '0;
					else                              rem_q <= rem_q + 1'b1;
				end
			end else begin
				mon_q <= mon_q + 1'b1;
			end
		end

		if (cmd.out_load) begin
			out_day_q  <= day_q[4:0];
			out_mon_q  <= mon_q;
			out_year_q <= year_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign new_day       = out_day_q;
	assign new_month     = out_mon_q;
	assign new_year      = out_year_q;
	assign year_overflow = out_ovf_q;

endmodule

// ----- rtl/date_add_days_core.sv -----
// After a transaction is accepted, the sequencer runs the year reduction and then the month walk,
//   then loads the output register, which raises out_valid, or first holds until the slot frees.
// One transaction at a time: a new one is accepted only once the previous result is loaded;
//   the month walk, one month per cycle, sets the rate.
// A finished result waits in the output register while the next transaction is taken.
// Reset (arst_n low, asynchronous): controller returns to idle, out_valid drops.
`include "date_add_days_core_assert.svh"

module date_add_days_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [4:0]                        start_day,
	input  logic [3:0]                        start_month,
	input  logic [dadd_pkg::YEAR_BITS-1:0]    start_year,
	input  logic [dadd_pkg::OFFSET_BITS-1:0]  days_away,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [4:0]                        new_day,
	output logic [3:0]                        new_month,
	output logic [dadd_pkg::YEAR_BITS-1:0]    new_year,
	output logic                              year_overflow
);

	// Command and status between sequencer and datapath.
	dadd_pkg::dadd_cmd_t cmd;
	dadd_pkg::dadd_sts_t sts;

	// Sequencer: idle -> year reduction -> month walk -> (hold until output slot frees).
	dadd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: date registers, mod-400 tracking for the leap rule, output register.
	dadd_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.sts           (sts),
		.start_day     (start_day),
		.start_month   (start_month),
		.start_year    (start_year),
		.days_away     (days_away),
		.new_day       (new_day),
		.new_month     (new_month),
		.new_year      (new_year),
		.year_overflow (year_overflow)
	);

	// Working commands never overlap: load, reduce and walk belong to distinct states.
	logic [2:0] work_cmds;
	assign work_cmds = {cmd.load, cmd.red_step, cmd.walk_step};

	// Result month lies in January through December.
	logic month_ok;
	assign month_ok = (new_month != dadd_pkg::MON_NONE) && (new_month <= dadd_pkg::MON_DEC);

	// Block goes busy right after taking a transaction.
	`DADD_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// Only one working command at a time.
	`DADD_ASSERT_IMP(a_one_work_cmd, clk, arst_n, 1'b1, $onehot0(work_cmds))
	// Months leave the block already clamped to January through December.
	`DADD_ASSERT_IMP(a_month_range, clk, arst_n, out_valid, month_ok)
	// A result is only loaded while no new transaction is being taken.
	`DADD_ASSERT_IMP(a_load_excl, clk, arst_n, cmd.out_load, !cmd.load)

endmodule

// ----- sim/date_add_days_core_tb.sv -----
module date_add_days_core_tb;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_ITEMS   = 250;
	// Run the tail of the random part with both sides always willing.
	localparam int QUIET_ITEMS    = 40;
	// Longest month walk plus the year reduction, rounded up.
	localparam int DRAIN_CYCLES   = 2200;
	// Cycles without any handshake before the run is called hung.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int unsigned YEAR_TOP = (1 << dadd_pkg::YEAR_BITS) - 1;
	localparam int unsigned SHORT_OFFSET = 1500;

	typedef logic [dadd_pkg::YEAR_BITS-1:0]   year_t;
	typedef logic [dadd_pkg::OFFSET_BITS-1:0] offset_t;

	typedef struct {
		logic [4:0] day;
		logic [3:0] month;
		year_t      year;
		logic       wrapped;
	} date_t;

	// Predicted dates wait here in transaction order until the block hands one back.
	class date_scoreboard;
		date_t       pending_dates[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function int unsigned month_days(logic [3:0] mon, int unsigned yr);
			bit leap;
			leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
			case (mon)
				dadd_pkg::MON_FEB: return leap ? 29 : 28;
				dadd_pkg::MON_APR, dadd_pkg::MON_JUN,
				dadd_pkg::MON_SEP, dadd_pkg::MON_NOV: return 30;
				default: return 31;
			endcase
		endfunction

		// Walk the calendar forward one month at a time, the same way the block does.
		function void note_input(logic [4:0] d, logic [3:0] m, year_t y, offset_t off);
			int unsigned day_sum;
			logic [3:0]  mon;
			int unsigned yr;
			int unsigned len;
			date_t       res;
			mon = m;
			if (mon == dadd_pkg::MON_NONE)
				mon = dadd_pkg::MON_JAN;
			if (mon > dadd_pkg::MON_DEC)
				mon = dadd_pkg::MON_DEC;
			yr = 32'(y);
			day_sum = 32'(d) + 32'(off);
			res.wrapped = 1'b0;
			len = month_days(mon, yr);
			while (day_sum > len) begin
				day_sum -= len;
				if (mon == dadd_pkg::MON_DEC) begin
					mon = dadd_pkg::MON_JAN;
					if (yr == YEAR_TOP) begin
						yr = 0;
						res.wrapped = 1'b1;
					end else begin
						yr++;
					end
				end else begin
					mon++;
				end
				len = month_days(mon, yr);
			end
			res.day   = day_sum[4:0];
			res.month = mon;
			res.year  = yr[dadd_pkg::YEAR_BITS-1:0];
			pending_dates.push_back(res);
		endfunction

		function void check_result(logic [4:0] d, logic [3:0] m, year_t y, logic ovf);
			date_t exp_date;
			if (pending_dates.size() == 0) begin
				$error("unexpected result %0d/%0d/%0d overflow %0d", y, m, d, ovf);
				errors++;
				return;
			end
			exp_date = pending_dates.pop_front();
			if (d !== exp_date.day) begin
				$error("new_day: expected %0d, actual %0d", exp_date.day, d);
				errors++;
			end
			if (m !== exp_date.month) begin
				$error("new_month: expected %0d, actual %0d", exp_date.month, m);
				errors++;
			end
			if (y !== exp_date.year) begin
				$error("new_year: expected %0d, actual %0d", exp_date.year, y);
				errors++;
			end
			if (ovf !== exp_date.wrapped) begin
				$error("year_overflow: expected %0d, actual %0d", exp_date.wrapped, ovf);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [4:0] start_day;
	logic [3:0] start_month;
	year_t      start_year;
	offset_t    days_away;
	logic       out_valid;
	logic       out_ready;
	logic [4:0] new_day;
	logic [3:0] new_month;
	year_t      new_year;
	logic       year_overflow;

	// Cleared near the end so the last transactions run back to back.
	bit bursts_on = 1'b1;

	date_scoreboard dates;
	int unsigned    stalled_cycles = 0;

	date_add_days_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_day     (start_day),
		.start_month   (start_month),
		.start_year    (start_year),
		.days_away     (days_away),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_day       (new_day),
		.new_month     (new_month),
		.new_year      (new_year),
		.year_overflow (year_overflow)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Present one date at the falling edge and hold it until the block takes it.
	// Return at the falling edge after the accept, with valid still high.
	task automatic send_date(input logic [4:0] d, input logic [3:0] m, input year_t y,
		input offset_t off);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid    = 1'b1;
		start_day   = d;
		start_month = m;
		start_year  = y;
		days_away   = off;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Result side: stall mostly right as a result shows up, now and then blindly.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (bursts_on && ((out_valid && $urandom_range(0, 1) == 0) ||
				$urandom_range(0, 39) == 0)) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// Observe both handshakes at the rising edge: check results before noting new
	// transactions, and watch for a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				dates.check_result(new_day, new_month, new_year, year_overflow);
			if (in_valid && in_ready)
				dates.note_input(start_day, start_month, start_year, days_away);
			if ((out_valid && out_ready) || (in_valid && in_ready)) begin
				stalled_cycles = 0;
			end else begin
				stalled_cycles++;
				if (stalled_cycles >= WATCHDOG_LIMIT) begin
					$display("date_add_days_core test failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned kind;
		logic [4:0]  d;
		logic [3:0]  m;
		year_t       y;
		offset_t     off;

		dates       = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		start_day   = '0;
		start_month = '0;
		start_year  = '0;
		days_away   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: field extremes, leap rules, clamped months, day zero, year wrap.
		send_date(5'd1,  dadd_pkg::MON_JAN, year_t'(0), offset_t'(0));
		send_date(5'd28, dadd_pkg::MON_FEB, year_t'(0), offset_t'(1));   // year zero is leap
		send_date(5'd31, dadd_pkg::MON_DEC, year_t'(YEAR_TOP), offset_t'(1)); // wrap to zero
		send_date(5'd31, 4'd15, year_t'(YEAR_TOP), '1);            // clamp to Dec, max offset
		send_date(5'd0,  dadd_pkg::MON_NONE, year_t'(2023), offset_t'(0)); // day zero kept
		send_date(5'd0,  4'd5,  year_t'(2023),  offset_t'(1));
		send_date(5'd31, dadd_pkg::MON_FEB, year_t'(2023), offset_t'(0)); // Feb 31 normalizes
		send_date(5'd31, dadd_pkg::MON_FEB, year_t'(2024), offset_t'(0));
		send_date(5'd28, dadd_pkg::MON_FEB, year_t'(1900), offset_t'(1)); // century, not leap
		send_date(5'd28, dadd_pkg::MON_FEB, year_t'(2000), offset_t'(1)); // quad century, leap
		send_date(5'd28, dadd_pkg::MON_FEB, year_t'(2100), offset_t'(1));
		send_date(5'd29, dadd_pkg::MON_FEB, year_t'(2024), offset_t'(365));
		send_date(5'd31, 4'd13, year_t'(2019),  offset_t'(1));     // month above twelve
		send_date(5'd1,  dadd_pkg::MON_JAN, year_t'(1), '1);
		send_date(5'd30, dadd_pkg::MON_APR, year_t'(2022), offset_t'(1));
		send_date(5'd31, dadd_pkg::MON_JAN, year_t'(YEAR_TOP), offset_t'(0));
		send_date(5'd15, dadd_pkg::MON_NONE, year_t'(YEAR_TOP), offset_t'(400));
		send_date(5'd31, 4'd7,  year_t'(9999),  offset_t'(31));
		send_date(5'd1,  dadd_pkg::MON_DEC, year_t'(YEAR_TOP - 1), offset_t'(396));
		send_date(5'd16, 4'd8,  year_t'(10922), offset_t'(21845)); // alternating bits
		send_date(5'd31, dadd_pkg::MON_DEC, year_t'(0), offset_t'(0));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_ITEMS)
				bursts_on = 1'b0;
			kind = $urandom_range(0, 9);
			d    = 5'($urandom_range(1, 31));
			m    = 4'($urandom_range(1, 12));
			y    = year_t'($urandom_range(0, YEAR_TOP));
			off  = offset_t'($urandom_range(0, SHORT_OFFSET));
			case (kind)
				6, 7: begin
					// Full-range offset: long walks across up to some 2150 months.
					off = offset_t'($urandom);
				end
				8: begin
					// Month ends around leap days, centuries and the year wrap.
					d = 5'($urandom_range(28, 31));
					if ($urandom_range(0, 1) == 0)
						y = year_t'($urandom_range(YEAR_TOP - 80, YEAR_TOP));
					else
						y = year_t'($urandom_range(0, YEAR_TOP / 100) * 100);
					if ($urandom_range(0, 1) == 0)
						m = dadd_pkg::MON_FEB;
					off = offset_t'($urandom_range(0, 3000));
				end
				9: begin
					// Malformed dates: day zero, months outside 1..12.
					d = 5'($urandom_range(0, 31));
					m = 4'($urandom_range(0, 15));
					if ($urandom_range(0, 3) == 0)
						off = offset_t'($urandom);
				end
				default: ;
			endcase
			send_date(d, m, y, off);
		end
		in_valid = 1'b0;

		// Drain: wait for every predicted date, then give stray results time to show.
		while (dates.pending_dates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (dates.errors == 0)
			$display("date_add_days_core test passed");
		else
			$display("date_add_days_core test failed");
		$finish;
	end

endmodule
